FILE: rtl/ncal_pkg.sv
`timescale 1ns / 1ps

package ncal_pkg;

	// Default sizes handed to the top level parameters
	localparam int NEURON_COUNT_DEF  = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	// Field and register widths
	localparam int IDX_W       = 10;
	localparam int IDX_EXT_W   = 17;  // holds any neuron count up to 65536
	localparam int CALC_W      = 32;
	localparam int STEPS_W     = 8;
	localparam int FRAC_W      = 17;
	localparam int DECAY_W     = 25;
	localparam int DECAY_FRAC  = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Datapath widths: c*decay, leak difference, difference*fraction, sum
	localparam int PROD1_W = CALC_W + DECAY_W + 1;
	localparam int DIFF_W  = PROD1_W - DECAY_FRAC;
	localparam int PROD2_W = DIFF_W + FRAC_W + 1;
	localparam int SUM_W   = PROD2_W + 1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_STEPS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRACTION = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECAY    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INCREMENT = 2'd3;

	// Register reset values
	localparam logic [STEPS_W-1:0]       STEPS_RST     = 8'd10;
	localparam logic [FRAC_W-1:0]        FRACTION_RST  = 17'd6554;
	localparam logic [DECAY_W-1:0]       DECAY_RST     = 25'd1678;
	localparam logic signed [CALC_W-1:0] INCREMENT_RST = 32'sd66;

	// Q16.16 limits
	localparam logic signed [CALC_W-1:0] CALC_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CALC_W-1:0] CALC_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [IDX_W-1:0] neuron_index;
		logic             fired;
		logic             disabled;
		logic             last_in_sweep;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        result_index;
		logic signed [CALC_W-1:0] calcium_value;
		logic                    updated;
		logic                    sweep_done;
		logic                    extremes_valid;
		logic [IDX_W-1:0]        minimum_index;
		logic [IDX_W-1:0]        maximum_index;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic take_item;
		logic load_value;
		logic step_mul1;
		logic step_mul2;
		logic step_acc;
		logic finish;
	} ncal_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic run;
		logic last_step;
		logic out_free;
	} ncal_status_t;

endpackage

FILE: rtl/ncal_stream_if.sv
`timescale 1ns / 1ps

interface ncal_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ncal_ram.sv
`timescale 1ns / 1ps

module ncal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/ncal_ctrl.sv
`timescale 1ns / 1ps

module ncal_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ncal_pkg::ncal_status_t status,
	output ncal_pkg::ncal_cmd_t    cmd
);

	import ncal_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_MUL2  = 3'd4;
	localparam logic [2:0] ST_ACC   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load_value = 1'b1;
				state_d        = status.run ? ST_MUL1 : ST_DONE;
			end
			ST_MUL1: begin
				cmd.step_mul1 = 1'b1;
				state_d       = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.step_mul2 = 1'b1;
				state_d       = ST_ACC;
			end
			ST_ACC: begin
				cmd.step_acc = 1'b1;
				state_d      = status.last_step ? ST_DONE : ST_MUL1;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/ncal_dpath.sv
`timescale 1ns / 1ps

module ncal_dpath #(
	parameter int NEURON_COUNT  = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ncal_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ncal_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ncal_pkg::in_item_t                  in_data,
	input  ncal_pkg::ncal_cmd_t                 cmd,
	output ncal_pkg::ncal_status_t              status,
	ncal_stream_if.source                       result_out
);

	import ncal_pkg::*;

	localparam int ADDR_W = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
	localparam logic [IDX_EXT_W-1:0] COUNT_EXT = IDX_EXT_W'(NEURON_COUNT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NEURON_COUNT - 1);
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(CALC_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(CALC_MIN);

	// Configuration registers
	logic [STEPS_W-1:0]       steps_q;
	logic [FRAC_W-1:0]        frac_q;
	logic [DECAY_W-1:0]       decay_q;
	logic signed [CALC_W-1:0] inc_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= STEPS_RST;
			frac_q    <= FRACTION_RST;
			decay_q   <= DECAY_RST;
			inc_cfg_q <= INCREMENT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_STEPS:     steps_q   <= cfg_data[STEPS_W-1:0];
				CFG_FRACTION:  frac_q    <= cfg_data[FRAC_W-1:0];
				CFG_DECAY:     decay_q   <= cfg_data[DECAY_W-1:0];
				CFG_INCREMENT: inc_cfg_q <= cfg_data[CALC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item decode
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 in_range;
	logic [ADDR_W-1:0]    rd_addr;

	assign idx_ext  = IDX_EXT_W'(in_data.neuron_index);
	assign in_range = idx_ext < COUNT_EXT;
	assign rd_addr  = idx_ext[ADDR_W-1:0];

	// Item registers
	logic [IDX_W-1:0]         idx_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     range_q;
	logic                     upd_q;
	logic                     last_q;
	logic signed [CALC_W-1:0] inc_q;
	logic [STEPS_W-1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			idx_q   <= in_data.neuron_index;
			addr_q  <= rd_addr;
			range_q <= in_range;
			upd_q   <= in_range && !in_data.disabled;
			last_q  <= in_data.last_in_sweep;
			inc_q   <= in_data.fired ? inc_cfg_q : '0;
		end
	end

	// Euler step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.take_item) begin
			cnt_q <= steps_q;
		end else if (cmd.step_acc) begin
			cnt_q <= cnt_q - STEPS_W'(1);
		end
	end

	// Clear sweep address
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Calcium store
	logic signed [CALC_W-1:0] c_q;
	logic [CALC_W-1:0]        ram_rdata;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [CALC_W-1:0]        ram_wdata;

	assign ram_we    = cmd.clear_wr || (cmd.finish && upd_q);
	assign ram_waddr = cmd.clear_wr ? clr_q : addr_q;
	assign ram_wdata = cmd.clear_wr ? '0 : c_q;

	ncal_ram #(
		.WIDTH (CALC_W),
		.DEPTH (NEURON_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.take_item),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Step arithmetic: leak product, difference product, add and saturate
	logic signed [PROD1_W-1:0] prod1_q;
	logic signed [PROD2_W-1:0] prod2_q;
	logic signed [DECAY_W:0]   decay_s;
	logic signed [FRAC_W:0]    frac_s;
	logic signed [DIFF_W-1:0]  leak;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD2_W-1:0] delta;
	logic signed [SUM_W-1:0]   sum;
	logic signed [CALC_W-1:0]  c_sat;

	assign decay_s = {1'b0, decay_q};
	assign frac_s  = {1'b0, frac_q};
	assign leak    = prod1_q[PROD1_W-1:DECAY_FRAC];
	assign diff    = DIFF_W'(inc_q) - leak;
	assign delta   = prod2_q >>> FRACTION_BITS;
	assign sum     = SUM_W'(delta) + SUM_W'(c_q);

	always_comb begin
		if (sum > SUM_MAX) begin
			c_sat = CALC_MAX;
		end else if (sum < SUM_MIN) begin
			c_sat = CALC_MIN;
		end else begin
			c_sat = sum[CALC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			c_q <= range_q ? ram_rdata : '0;
		end else if (cmd.step_acc) begin
			c_q <= c_sat;
		end
		if (cmd.step_mul1) begin
			prod1_q <= PROD1_W'(c_q) * PROD1_W'(decay_s);
		end
		if (cmd.step_mul2) begin
			prod2_q <= PROD2_W'(diff) * PROD2_W'(frac_s);
		end
	end

	// Running extremes over the sweep
	logic signed [CALC_W-1:0] min_q;
	logic signed [CALC_W-1:0] max_q;
	logic [IDX_W-1:0]         min_idx_q;
	logic [IDX_W-1:0]         max_idx_q;
	logic                     seen_q;
	logic                     take_min;
	logic                     take_max;
	logic                     ext_valid;
	logic [IDX_W-1:0]         min_idx_now;
	logic [IDX_W-1:0]         max_idx_now;

	assign take_min    = upd_q && (!seen_q || (c_q < min_q));
	assign take_max    = upd_q && (!seen_q || (c_q > max_q));
	assign ext_valid   = seen_q || upd_q;
	assign min_idx_now = take_min ? idx_q : min_idx_q;
	assign max_idx_now = take_max ? idx_q : max_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= CALC_MAX;
			max_q     <= CALC_MIN;
			min_idx_q <= '0;
			max_idx_q <= '0;
			seen_q    <= 1'b0;
		end else if (cmd.finish) begin
			if (last_q) begin
				min_q     <= CALC_MAX;
				max_q     <= CALC_MIN;
				min_idx_q <= '0;
				max_idx_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				if (take_min) begin
					min_q     <= c_q;
					min_idx_q <= idx_q;
				end
				if (take_max) begin
					max_q     <= c_q;
					max_idx_q <= idx_q;
				end
				if (upd_q) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// Output register
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.result_index   <= idx_q;
			out_q.calcium_value  <= c_q;
			out_q.updated        <= upd_q;
			out_q.sweep_done     <= last_q;
			out_q.extremes_valid <= last_q && ext_valid;
			out_q.minimum_index  <= (last_q && ext_valid) ? min_idx_now : '0;
			out_q.maximum_index  <= (last_q && ext_valid) ? max_idx_now : '0;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	// Status to the controller
	assign status.clear_last = (clr_q == LAST_ADDR);
	assign status.run        = upd_q && (cnt_q != '0);
	assign status.last_step  = (cnt_q == STEPS_W'(1));
	assign status.out_free   = !out_valid_q || result_out.ready;

endmodule

FILE: rtl/neuron_calcium_euler_update.sv
`timescale 1ns / 1ps
// Channel      Dir  Payload                        Handshake
// item_in      in   in_item_t (index, flags)       valid/ready, taken when both high
// result_out   out  out_item_t (calcium, extremes) valid/ready, taken when both high
// cfg_*        in   index, data                    write on cfg_wr_en
//
// An item runs from accept through a store read, steps_per_update Euler steps and
// finish: each Euler step runs the c*decay multiply, the difference*fraction
// multiply and the add with saturation in turn. A disabled item skips the Euler
// steps. No new item is accepted until the current one has finished.
// After reset the calcium store is swept to zero with no item accepted. A waiting
// result sits in the output register while the next item is taken; that item
// finishes only once the register is free.

module neuron_calcium_euler_update #(
	parameter int NEURON_COUNT  = ncal_pkg::NEURON_COUNT_DEF,
	parameter int FRACTION_BITS = ncal_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ncal_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ncal_pkg::CFG_DATA_W-1:0]   cfg_data,
	ncal_stream_if.sink                       item_in,
	ncal_stream_if.source                     result_out
);

	import ncal_pkg::*;

	ncal_cmd_t    cmd;
	ncal_status_t status;
	logic         in_ready;

	assign item_in.ready = in_ready;

	ncal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ncal_dpath #(
		.NEURON_COUNT  (NEURON_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (item_in.data),
		.cmd        (cmd),
		.status     (status),
		.result_out (result_out)
	);

	// No item is taken while the store is being cleared
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !item_in.ready)
		else $error("item taken during store clear");

	// One item at a time: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> !item_in.ready)
		else $error("second item accepted while one is in work");

	// A finished item never overwrites a result still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result_out.valid || result_out.ready))
		else $error("result overwritten before it was taken");

	// A finished item shows up at the output next cycle
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_out.valid)
		else $error("finished item not presented");

endmodule
